FILE: rtl/aptgc_pkg.sv
// Shared types, constants and register codes of the aim-point geometry checker.
package aptgc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int NUM_WIDTH           = 28;   // (sight * focal) >> 4
   localparam int DEN_WIDTH           = 15;   // positive distance, Q7.8
   localparam int DIFF_WIDTH          = NUM_WIDTH + 2;
   localparam int DIV_STEPS           = NUM_WIDTH / 2;   // two quotient bits a cycle
   localparam int SPEED_SLOW_MAX      = 25;   // |speed| * 10 < 256

   localparam logic [14:0] IMAGE_WIDTH_RESET      = 15'd10240;
   localparam logic [14:0] IMAGE_HEIGHT_RESET     = 15'd7680;
   localparam logic [15:0] FOCAL_LENGTH_RESET     = 16'd8000;
   localparam logic [15:0] SIGHT_HEIGHT_RESET     = 16'd205;
   localparam logic [15:0] ALIGN_TOLERANCE_RESET  = 16'd80;
   localparam logic [15:0] OFFSET_TOLERANCE_RESET = 16'd80;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_FOCAL_LENGTH,
      REG_SIGHT_HEIGHT,
      REG_ALIGN_TOLERANCE,
      REG_OFFSET_TOLERANCE
   } aptgc_reg_type;

   typedef enum logic [1:0] {
      KIND_COORD,
      KIND_FULL,
      KIND_CLEAR
   } aptgc_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_NEG_X,
      ERR_NEG_Y,
      ERR_WIDTH,
      ERR_HEIGHT,
      ERR_DISTANCE,
      ERR_OFFSET,
      ERR_ALIGN
   } aptgc_err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH
   } aptgc_state_type;

   typedef struct packed {
      logic [14:0] image_width;
      logic [14:0] image_height;
      logic [15:0] focal_length;
      logic [15:0] sight_height;
      logic [15:0] align_tolerance;
      logic [15:0] offset_tolerance;
   } aptgc_cfg_type;

   // One classified request as it waits for the back end.
   typedef struct packed {
      logic [1:0]           kind;
      logic [2:0]           bounds_code;
      logic                 dist_ok;
      logic                 needs_div;
      logic                 slow;
      logic signed [16:0]   dy;
      logic [15:0]          adx;
      logic [NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0] den;
      logic [31:0]          stamp;
   } aptgc_job_type;

endpackage

FILE: rtl/aptgc_req_if.sv
// Request channel of the aim-point geometry checker.
interface aptgc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] aim_x;
   logic signed [15:0] aim_y;
   logic signed [15:0] box_x;
   logic signed [15:0] box_y;
   logic signed [15:0] distance;
   logic signed [15:0] speed_x;
   logic [31:0]        stamp;

   modport source (output valid, kind, aim_x, aim_y, box_x, box_y, distance, speed_x, stamp,
                   input ready);
   modport sink   (input valid, kind, aim_x, aim_y, box_x, box_y, distance, speed_x, stamp,
                   output ready);
endinterface

FILE: rtl/aptgc_rsp_if.sv
// Result channel of the aim-point geometry checker.
interface aptgc_rsp_if;
   logic        valid;
   logic        ready;
   logic        passed;
   logic [2:0]  fail_code;
   logic [31:0] stamp_out;
   logic [31:0] total_count;
   logic [31:0] bounds_count;
   logic [31:0] offset_count;
   logic [31:0] align_count;

   modport source (output valid, passed, fail_code, stamp_out, total_count, bounds_count,
                   offset_count, align_count, input ready);
   modport sink   (input valid, passed, fail_code, stamp_out, total_count, bounds_count,
                   offset_count, align_count, output ready);
endinterface

FILE: rtl/aptgc_front.sv
// Front end: accepts requests, runs the bounds and distance tests, prepares the divide.
module aptgc_front (
   aptgc_req_if.sink             req,
   input  aptgc_pkg::aptgc_cfg_type cfg,
   input  logic                  queue_full,
   output logic                  push,
   output aptgc_pkg::aptgc_job_type job
);
   import aptgc_pkg::*;

   logic [31:0]        product;
   logic signed [16:0] dx;
   logic [2:0]         bcode;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      // first failing bound wins
      if (req.aim_x[15])
         bcode = ERR_NEG_X;
      else if (req.aim_y[15])
         bcode = ERR_NEG_Y;
      else if (req.aim_x[14:0] > cfg.image_width)
         bcode = ERR_WIDTH;
      else if (req.aim_y[14:0] > cfg.image_height)
         bcode = ERR_HEIGHT;
      else
         bcode = ERR_NONE;

      product = cfg.sight_height * cfg.focal_length;
      dx      = {req.box_x[15], req.box_x} - {req.aim_x[15], req.aim_x};

      job.kind        = req.kind;
      job.bounds_code = bcode;
      job.dist_ok     = !req.distance[15] && (req.distance != 16'sd0);
      job.needs_div   = (req.kind == KIND_FULL) && (bcode == ERR_NONE) && job.dist_ok;
      job.slow        = (req.speed_x <= 16'(SPEED_SLOW_MAX))
                        && (req.speed_x >= -16'(SPEED_SLOW_MAX));
      job.dy          = {req.box_y[15], req.box_y} - {req.aim_y[15], req.aim_y};
      job.adx         = dx[16] ? 16'(-dx) : dx[15:0];
      job.num         = product[31:4];
      job.den         = req.distance[DEN_WIDTH-1:0];
      job.stamp       = req.stamp;
   end

endmodule

FILE: rtl/aptgc_queue.sv
// Short register queue between front and back end.
module aptgc_queue #(
   parameter int DEPTH = aptgc_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  aptgc_pkg::aptgc_job_type push_job,
   output logic                     full,
   input  logic                     pop,
   output aptgc_pkg::aptgc_job_type head_job,
   output logic                     empty
);
   import aptgc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   aptgc_job_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: rtl/aptgc_back.sv
// Back end: radix-4 divider for the expected offset, final checks, counters, result register.
module aptgc_back #(
   parameter int COUNT_WIDTH = aptgc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  aptgc_pkg::aptgc_cfg_type cfg,
   input  logic                     queue_empty,
   input  aptgc_pkg::aptgc_job_type head_job,
   output logic                     queue_pop,
   aptgc_rsp_if.source              rsp
);
   import aptgc_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   function automatic logic [DEN_WIDTH:0] div_step(input logic [DEN_WIDTH-1:0] r,
                                                   input logic b,
                                                   input logic [DEN_WIDTH-1:0] d);
      logic [DEN_WIDTH:0] t;
      logic [DEN_WIDTH:0] s;
      t = {r, b};
      s = t - {1'b0, d};
      if (t >= {1'b0, d})
         return {1'b1, s[DEN_WIDTH-1:0]};
      else
         return {1'b0, t[DEN_WIDTH-1:0]};
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [31:0] low32(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH+31:0] e;
      e = {32'd0, c};
      return e[31:0];
   endfunction

   aptgc_state_type       state_ff, state_in;
   aptgc_job_type         job_ff, job_in;
   logic [NUM_WIDTH-1:0]  num_ff, num_in;
   logic [NUM_WIDTH-1:0]  quot_ff, quot_in;
   logic [DEN_WIDTH-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] bounds_ff, bounds_in;
   logic [COUNT_WIDTH-1:0] offset_ff, offset_in;
   logic [COUNT_WIDTH-1:0] align_ff, align_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        passed_ff, passed_in;
   logic [2:0]  code_ff, code_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] total_out_ff, bounds_out_ff, offset_out_ff, align_out_ff;

   logic [DEN_WIDTH:0]          step_a, step_b;
   logic signed [DIFF_WIDTH-1:0] diff;
   logic [DIFF_WIDTH-1:0]       adiff;
   logic                        off_bad;
   logic                        clear;
   logic                        load;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // two restoring steps a cycle
   always_comb begin
      step_a = div_step(rem_ff, num_ff[NUM_WIDTH-1], job_ff.den);
      step_b = div_step(step_a[DEN_WIDTH-1:0], num_ff[NUM_WIDTH-2], job_ff.den);
   end

   // final classification of the job in hand
   always_comb begin
      diff    = {{(DIFF_WIDTH-17){job_ff.dy[16]}}, job_ff.dy} - {2'b00, quot_ff};
      adiff   = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : diff;
      off_bad = adiff > {{(DIFF_WIDTH-16){1'b0}}, cfg.offset_tolerance};
      clear   = 1'b0;
      code_in = ERR_NONE;
      passed_in = 1'b0;
      case (job_ff.kind)
         KIND_COORD: begin
            code_in   = job_ff.bounds_code;
            passed_in = (job_ff.bounds_code == ERR_NONE);
         end
         KIND_FULL: begin
            if (job_ff.bounds_code != ERR_NONE)
               code_in = job_ff.bounds_code;
            else if (!job_ff.dist_ok)
               code_in = ERR_DISTANCE;
            else if (off_bad)
               code_in = ERR_OFFSET;
            else if (job_ff.slow && (job_ff.adx > cfg.align_tolerance))
               code_in = ERR_ALIGN;
            passed_in = (code_in == ERR_NONE);
         end
         KIND_CLEAR: begin
            clear     = 1'b1;
            passed_in = 1'b1;
         end
         default: ;
      endcase
      stamp_in = job_ff.stamp;
   end

   always_comb begin
      total_in  = total_ff;
      bounds_in = bounds_ff;
      offset_in = offset_ff;
      align_in  = align_ff;
      if (clear) begin
         total_in  = '0;
         bounds_in = '0;
         offset_in = '0;
         align_in  = '0;
      end else if (code_in != ERR_NONE) begin
         total_in = sat_inc(total_ff);
         case (code_in) inside
            ERR_NEG_X, ERR_NEG_Y, ERR_WIDTH, ERR_HEIGHT: bounds_in = sat_inc(bounds_ff);
            ERR_OFFSET: offset_in = sat_inc(offset_ff);
            ERR_ALIGN:  align_in  = sat_inc(align_ff);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      num_in    = num_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      queue_pop = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in    = head_job;
               num_in    = head_job.num;
               quot_in   = '0;
               rem_in    = '0;
               step_in   = '0;
               state_in  = head_job.needs_div ? ST_DIV : ST_FINISH;
            end
         end
         ST_DIV: begin
            num_in  = {num_ff[NUM_WIDTH-3:0], 2'b00};
            quot_in = {quot_ff[NUM_WIDTH-3:0], step_a[DEN_WIDTH], step_b[DEN_WIDTH]};
            rem_in  = step_b[DEN_WIDTH-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1))
               state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         bounds_ff    <= '0;
         offset_ff    <= '0;
         align_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            total_ff  <= total_in;
            bounds_ff <= bounds_in;
            offset_ff <= offset_in;
            align_ff  <= align_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (load) begin
         passed_ff     <= passed_in;
         code_ff       <= code_in;
         stamp_ff      <= stamp_in;
         total_out_ff  <= low32(total_in);
         bounds_out_ff <= low32(bounds_in);
         offset_out_ff <= low32(offset_in);
         align_out_ff  <= low32(align_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.passed       = passed_ff;
   assign rsp.fail_code    = code_ff;
   assign rsp.stamp_out    = stamp_ff;
   assign rsp.total_count  = total_out_ff;
   assign rsp.bounds_count = bounds_out_ff;
   assign rsp.offset_count = offset_out_ff;
   assign rsp.align_count  = align_out_ff;

endmodule

FILE: rtl/aim_point_geometry_checker_core.sv
// Top level of the aim-point geometry checker: configuration registers and the three stages.
//
// Usage:
//   req carries one request: a coordinate check, a full aim check or a counter
//   clear; it is taken on a clock edge with req.valid and req.ready high.
//   rsp returns exactly one result per request, in order, with the error code
//   and the four saturating error counters as they stand after that request.
//   csr_we/csr_index/csr_wdata write the six geometry registers; write them
//   only while no request is in flight.
// Timing:
//   A coordinate check, a clear or a full check that fails before the divide
//   goes from the queue pop straight to the finish state; a full check that
//   reaches the offset test goes from the pop through the divide, two quotient
//   bits per step, to the finish. The back end pops the next request only after
//   loading the last result; the front end keeps taking requests into a 2-entry
//   queue while the divider works or the result register waits.
// Reset: synchronous, active high. Counters clear, registers take their
//   defaults, queue and result register empty.
// Stall: a result holds in the output register until rsp.ready; the back end
//   then stops, the queue fills and req.ready drops.
module aim_point_geometry_checker_core #(
   parameter int COUNT_WIDTH = aptgc_pkg::COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = aptgc_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   aptgc_req_if.sink                             req,
   aptgc_rsp_if.source                           rsp,
   input  logic                                  csr_we,
   input  logic [aptgc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [aptgc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import aptgc_pkg::*;

   aptgc_cfg_type cfg_ff, cfg_in;
   aptgc_job_type push_job, head_job;
   logic          push, queue_full, queue_pop, queue_empty;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:      cfg_in.image_width      = csr_wdata[14:0];
            REG_IMAGE_HEIGHT:     cfg_in.image_height     = csr_wdata[14:0];
            REG_FOCAL_LENGTH:     cfg_in.focal_length     = csr_wdata;
            REG_SIGHT_HEIGHT:     cfg_in.sight_height     = csr_wdata;
            REG_ALIGN_TOLERANCE:  cfg_in.align_tolerance  = csr_wdata;
            REG_OFFSET_TOLERANCE: cfg_in.offset_tolerance = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height     <= IMAGE_HEIGHT_RESET;
         cfg_ff.focal_length     <= FOCAL_LENGTH_RESET;
         cfg_ff.sight_height     <= SIGHT_HEIGHT_RESET;
         cfg_ff.align_tolerance  <= ALIGN_TOLERANCE_RESET;
         cfg_ff.offset_tolerance <= OFFSET_TOLERANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify each request as it arrives
   aptgc_front u_front (
      .req        (req),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   aptgc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   // divide, final checks, counters and result register
   aptgc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

endmodule
